@@ src/bpa_pkg.sv @@
// Shared types, constants and helper functions of the bitmap page allocator.
// Used by every module of the block; depends on nothing else.

package bpa_pkg;

    // Sizes of the managed page map.
    localparam int NUM_PAGES      = 4096;
    localparam int RESERVED_PAGES = 256;
    localparam int PAGE_BYTES     = 4096;
    localparam int PAGE_SHIFT     = $clog2(PAGE_BYTES);

    // One map word holds the used bits of 32 pages.
    localparam int WORD_BITS  = 32;
    localparam int BIT_IDX_W  = $clog2(WORD_BITS);
    localparam int MAP_WORDS  = NUM_PAGES / WORD_BITS;
    localparam int WORD_IDX_W = $clog2(MAP_WORDS);
    localparam int PAGE_IDX_W = $clog2(NUM_PAGES);
    localparam int RES_WORD   = RESERVED_PAGES / WORD_BITS;
    localparam int RES_BIT    = RESERVED_PAGES % WORD_BITS;

    // Field widths of the transactions.
    localparam int ADDR_W     = 32;
    localparam int ACT_W      = 2;
    localparam int CNT_W      = 13;
    localparam int TOTAL_W    = 32;
    localparam int PAGE_NUM_W = ADDR_W - PAGE_SHIFT;
    localparam int IN_W       = 40;
    localparam int OUT_FIELDS_W = 1 + ADDR_W + 1 + CNT_W + CNT_W + TOTAL_W;
    localparam int OUT_W      = 96;
    localparam int OUT_PAD_W  = OUT_W - OUT_FIELDS_W;

    // Configuration port.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_TOTAL_PAGES = 1'b0;
    localparam int TOTAL_RESET = 4096;

    // Command queue between front and back.
    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);

    typedef logic [CNT_W-1:0]      cnt_t;
    typedef logic [WORD_BITS-1:0]  word_t;
    typedef logic [WORD_IDX_W-1:0] widx_t;

    localparam cnt_t  CNT_MAX    = {CNT_W{1'b1}};
    localparam cnt_t  RESET_USED = CNT_W'(RESERVED_PAGES);
    localparam widx_t START_WORD = WORD_IDX_W'(RES_WORD);

    typedef enum logic [ACT_W-1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_QUERY = 2'd2,
        OP_NOP   = 2'd3
    } op_t;

    // Classified command handed from the front to the back.
    typedef struct packed {
        op_t                   op;
        logic [PAGE_IDX_W-1:0] page;
        logic                  in_map;
        logic                  free_range;
    } cmd_t;

    typedef enum logic {
        ST_IDLE,
        ST_CHECK
    } bk_state_t;

    // Page limit is the configured page count capped at the map size.
    function automatic cnt_t limit_of(input cnt_t total);
        limit_of = (total > CNT_W'(NUM_PAGES)) ? CNT_W'(NUM_PAGES) : total;
    endfunction

    // Free pages right after initialization for a given limit.
    function automatic cnt_t initial_free(input cnt_t lim);
        initial_free = (lim > CNT_W'(RESERVED_PAGES)) ? lim - CNT_W'(RESERVED_PAGES) : '0;
    endfunction

    // Bits of map word w whose pages lie at or above the reserved region.
    function automatic word_t res_mask(input widx_t w);
        cnt_t wz;
        wz = CNT_W'(w);
        if (wz > CNT_W'(RES_WORD)) begin
            res_mask = '1;
        end else if (wz == CNT_W'(RES_WORD)) begin
            res_mask = ~((word_t'(1) << RES_BIT) - word_t'(1));
        end else begin
            res_mask = '0;
        end
    endfunction

    // Bits of map word w whose pages lie below the page limit.
    function automatic word_t lim_mask(input widx_t w, input cnt_t lim);
        logic [CNT_W-BIT_IDX_W-1:0] hi;
        logic [CNT_W-BIT_IDX_W-1:0] wz;
        hi = lim[CNT_W-1:BIT_IDX_W];
        wz = (CNT_W-BIT_IDX_W)'(w);
        if (wz < hi) begin
            lim_mask = '1;
        end else if (wz == hi) begin
            lim_mask = (word_t'(1) << lim[BIT_IDX_W-1:0]) - word_t'(1);
        end else begin
            lim_mask = '0;
        end
    endfunction

    // Contents of map word w right after initialization: reserved pages used.
    function automatic word_t reset_word(input widx_t w);
        reset_word = ~res_mask(w);
    endfunction

endpackage

@@ src/bitmap_page_allocator.sv @@
// Bitmap page allocator, top level: configuration register and block assembly.
// Depends on bpa_pkg, bpa_front, bpa_cmd_fifo and bpa_back.
//
// Usage: each input transaction on the s_ channel carries an action (allocate,
// free, query) and a page byte address; each produces exactly one result
// transaction on the m_ channel with ok, the allocated address, the queried
// used bit and the used, free and allocation counts after the action.
// The front classifies a transaction in the cycle it is accepted and queues it
// (two entries). The back reads the 128-word by 32-bit page map through one
// port, one word per cycle. Free and query read their one map word and finish in
// the back's check state; an allocation scans map words one after another from
// the first word above the reserved region, up to 120 words when the map is full.
// The result is valid on the cycle after the back finishes.
// Reset marks the reserved pages used and all others free at once through
// per-row valid bits; no clearing pass is needed. Writing total_pages over
// the APB port re-initializes the map and page counts the same way.
// When the receiver stalls, the result stays in the output register and the
// back holds the next command; the queue keeps taking input until it fills.

module bitmap_page_allocator (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [bpa_pkg::IN_W-1:0]        s_tdata,   // action[1:0], page_address[33:2]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // ok[0], alloc_address[32:1], page_used[33], used_count[46:34],
    // free_count[59:47], alloc_total[91:60], zero fill above
    output logic [bpa_pkg::OUT_W-1:0]       m_tdata,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [bpa_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [bpa_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [bpa_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);
    import bpa_pkg::*;

    cnt_t total_reg, total_next;
    cnt_t page_limit;
    cnt_t wr_limit;
    logic cfg_wr;
    logic cfg_init;
    logic push;
    cmd_t push_cmd;
    logic q_full;
    logic q_pop;
    logic q_valid;
    cmd_t q_cmd;

    // Configuration register write and read back.
    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign cfg_init = cfg_wr && (paddr[2] == REG_TOTAL_PAGES);
    assign wr_limit = limit_of(pwdata[CNT_W-1:0]);

    always_comb begin
        total_next = total_reg;
        if (cfg_init) begin
            total_next = pwdata[CNT_W-1:0];
        end
    end

    always_comb begin
        if (paddr[2] == REG_TOTAL_PAGES) begin
            prdata = APB_DATA_W'(total_reg);
        end else begin
            prdata = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg <= CNT_W'(TOTAL_RESET);
        end else begin
            total_reg <= total_next;
        end
    end

    assign page_limit = limit_of(total_reg);

    bpa_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .page_limit (page_limit),
        .q_full     (q_full),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    bpa_cmd_fifo u_cmd_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_cmd   (q_cmd)
    );

    bpa_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .page_limit (page_limit),
        .cfg_init   (cfg_init),
        .cfg_free   (initial_free(wr_limit)),
        .q_valid    (q_valid),
        .q_cmd      (q_cmd),
        .q_pop      (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

@@ src/bpa_front.sv @@
// Front of the bitmap page allocator: takes input transactions and classifies them.
// Depends on bpa_pkg; feeds the command queue.

module bpa_front (
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [bpa_pkg::IN_W-1:0]  s_tdata,    // action[1:0], page_address[33:2]
    input  bpa_pkg::cnt_t             page_limit,
    input  logic                      q_full,
    output logic                      push,
    output bpa_pkg::cmd_t             push_cmd
);
    import bpa_pkg::*;

    logic [ACT_W-1:0]      action;
    logic [ADDR_W-1:0]     page_address;
    logic [PAGE_NUM_W-1:0] page_num;

    // Unpack the transaction.
    assign action       = s_tdata[ACT_W-1:0];
    assign page_address = s_tdata[ACT_W+ADDR_W-1:ACT_W];
    assign page_num     = page_address[ADDR_W-1:PAGE_SHIFT];

    // Accept whenever the queue has room.
    assign s_tready = !q_full;
    assign push     = s_tvalid && !q_full;

    // Work out the range checks once, so the back only sees flags.
    always_comb begin
        push_cmd.op         = op_t'(action);
        push_cmd.page       = page_num[PAGE_IDX_W-1:0];
        push_cmd.in_map     = page_num < PAGE_NUM_W'(NUM_PAGES);
        push_cmd.free_range = (page_num >= PAGE_NUM_W'(RESERVED_PAGES)) &&
                              (page_num < PAGE_NUM_W'(page_limit));
    end

endmodule

@@ src/bpa_cmd_fifo.sv @@
// Short command queue between the front and the back of the page allocator.
// Depends on bpa_pkg for the command type and the queue depth.

module bpa_cmd_fifo (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  bpa_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          pop_valid,
    output bpa_pkg::cmd_t pop_cmd
);
    import bpa_pkg::*;

    cmd_t                q_mem [CMDQ_DEPTH];
    logic [CMDQ_AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [CMDQ_AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CMDQ_AW:0]    count_reg, count_next;
    logic                do_push, do_pop;

    // Status and head entry.
    assign full      = count_reg == (CMDQ_AW+1)'(CMDQ_DEPTH);
    assign pop_valid = count_reg != '0;
    assign pop_cmd   = q_mem[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    // Pointer and fill count updates.
    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            q_mem[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

@@ src/bpa_back.sv @@
// Back of the bitmap page allocator: page map memory, counters, scan sequencer
// and output register. Depends on bpa_pkg; takes commands from bpa_cmd_fifo.

module bpa_back (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  bpa_pkg::cnt_t             page_limit,
    input  logic                      cfg_init,
    input  bpa_pkg::cnt_t             cfg_free,
    input  logic                      q_valid,
    input  bpa_pkg::cmd_t             q_cmd,
    output logic                      q_pop,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // ok[0], alloc_address[32:1], page_used[33], used_count[46:34],
    // free_count[59:47], alloc_total[91:60], zero fill above
    output logic [bpa_pkg::OUT_W-1:0] m_tdata
);
    import bpa_pkg::*;

    bk_state_t            state_reg, state_next;
    cmd_t                 cmd_reg, cmd_next;
    widx_t                word_reg, word_next;
    cnt_t                 used_reg, used_next;
    cnt_t                 free_reg, free_next;
    logic [TOTAL_W-1:0]   alloc_cnt_reg, alloc_cnt_next;
    logic                 out_valid_reg, out_valid_next;

    logic                 out_ok_reg;
    logic [ADDR_W-1:0]    out_addr_reg;
    logic                 out_page_used_reg;
    cnt_t                 out_used_reg;
    cnt_t                 out_free_reg;
    logic [TOTAL_W-1:0]   out_total_reg;

    word_t                map_mem [MAP_WORDS];
    word_t                rd_data_reg;
    logic                 rd_valid_reg;
    logic [MAP_WORDS-1:0] row_valid_reg;

    logic                 rd_en;
    widx_t                rd_addr;
    logic                 wr_en;
    word_t                wr_data;

    word_t                eff_word;
    word_t                cand;
    logic                 found;
    logic [BIT_IDX_W-1:0] found_bit;
    logic                 cur_bit;
    cnt_t                 lim_m1;
    widx_t                last_word;
    logic                 done;
    logic                 res_ok;
    logic [ADDR_W-1:0]    res_addr;
    logic                 res_page_used;

    // Map word as last read; a row never written since init holds its reset value.
    assign eff_word = rd_valid_reg ? rd_data_reg : reset_word(word_reg);
    assign cur_bit  = eff_word[cmd_reg.page[BIT_IDX_W-1:0]];

    // Free candidates in the current word and the lowest of them.
    assign cand  = ~eff_word & res_mask(word_reg) & lim_mask(word_reg, page_limit);
    assign found = |cand;
    always_comb begin
        found_bit = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (cand[i]) begin
                found_bit = BIT_IDX_W'(i);
            end
        end
    end

    // Last map word that holds a page below the limit.
    assign lim_m1    = page_limit - 1'b1;
    assign last_word = (page_limit == '0) ? '0 : lim_m1[PAGE_IDX_W-1:BIT_IDX_W];

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (q_pop) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (done) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs and datapath.
    always_comb begin
        q_pop          = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = word_reg;
        wr_en          = 1'b0;
        wr_data        = eff_word;
        done           = 1'b0;
        res_ok         = 1'b0;
        res_addr       = '0;
        res_page_used  = 1'b0;
        cmd_next       = cmd_reg;
        word_next      = word_reg;
        used_next      = used_reg;
        free_next      = free_reg;
        alloc_cnt_next = alloc_cnt_reg;
        case (state_reg)
            ST_IDLE: begin
                // Take a command only when the output register will be free.
                q_pop = q_valid && (!out_valid_reg || m_tready);
                if (q_pop) begin
                    cmd_next = q_cmd;
                    rd_en    = 1'b1;
                    rd_addr  = (q_cmd.op == OP_ALLOC) ? START_WORD :
                               q_cmd.page[PAGE_IDX_W-1:BIT_IDX_W];
                    word_next = rd_addr;
                end
            end
            ST_CHECK: begin
                case (cmd_reg.op)
                    OP_QUERY: begin
                        done          = 1'b1;
                        res_page_used = cmd_reg.in_map && cur_bit;
                    end
                    OP_FREE: begin
                        done = 1'b1;
                        if (cmd_reg.free_range && cur_bit) begin
                            wr_en   = 1'b1;
                            wr_data = eff_word &
                                      ~(word_t'(1) << cmd_reg.page[BIT_IDX_W-1:0]);
                            res_ok  = 1'b1;
                            used_next = (used_reg == '0) ? used_reg : used_reg - 1'b1;
                            free_next = (free_reg == CNT_MAX) ? free_reg : free_reg + 1'b1;
                        end
                    end
                    OP_ALLOC: begin
                        if (found) begin
                            done      = 1'b1;
                            wr_en     = 1'b1;
                            wr_data   = eff_word | (word_t'(1) << found_bit);
                            res_ok    = 1'b1;
                            res_addr  = ADDR_W'({word_reg, found_bit}) << PAGE_SHIFT;
                            used_next = (used_reg == CNT_MAX) ? used_reg : used_reg + 1'b1;
                            free_next = (free_reg == '0) ? free_reg : free_reg - 1'b1;
                            alloc_cnt_next = alloc_cnt_reg + 1'b1;
                        end else if (word_reg >= last_word) begin
                            done = 1'b1;
                        end else begin
                            // Step to the next word; one word per cycle.
                            rd_en     = 1'b1;
                            rd_addr   = word_reg + 1'b1;
                            word_next = rd_addr;
                        end
                    end
                    default: done = 1'b1;
                endcase
            end
            default: ;
        endcase
    end

    // Output register handshake.
    always_comb begin
        out_valid_next = out_valid_reg;
        if (done) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    // Control state and counters.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            used_reg      <= RESET_USED;
            free_reg      <= initial_free(limit_of(CNT_W'(TOTAL_RESET)));
            alloc_cnt_reg <= '0;
            row_valid_reg <= '0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            alloc_cnt_reg <= alloc_cnt_next;
            if (cfg_init) begin
                used_reg      <= RESET_USED;
                free_reg      <= cfg_free;
                row_valid_reg <= '0;
            end else begin
                used_reg <= used_next;
                free_reg <= free_next;
                if (wr_en) begin
                    row_valid_reg[word_reg] <= 1'b1;
                end
            end
        end
    end

    // Command, scan position and result payload.
    always_ff @(posedge aclk) begin
        cmd_reg  <= cmd_next;
        word_reg <= word_next;
        if (done) begin
            out_ok_reg        <= res_ok;
            out_addr_reg      <= res_addr;
            out_page_used_reg <= res_page_used;
            out_used_reg      <= used_next;
            out_free_reg      <= free_next;
            out_total_reg     <= alloc_cnt_next;
        end
    end

    // Page map memory with registered read.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            map_mem[word_reg] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg  <= map_mem[rd_addr];
            rd_valid_reg <= row_valid_reg[rd_addr];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{OUT_PAD_W{1'b0}}, out_total_reg, out_free_reg, out_used_reg,
                       out_page_used_reg, out_addr_reg, out_ok_reg};

    // A result is only produced into an empty output register.
    a_done_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        done |-> !out_valid_reg)
        else $error("result produced while output register still full");

    // A written map row reads back its stored contents afterwards.
    a_wr_marks_row: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en && !cfg_init |=> row_valid_reg[$past(word_reg)])
        else $error("written map row not marked valid");

    // The allocation scan never looks below the reserved region.
    a_scan_above_reserved: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_CHECK && cmd_reg.op == OP_ALLOC |-> word_reg >= START_WORD)
        else $error("allocation scan entered the reserved region");

    // The allocation count moves only on a successful allocation.
    a_alloc_count: assert property (@(posedge aclk) disable iff (!aresetn)
        alloc_cnt_next != alloc_cnt_reg |-> done && res_ok && cmd_reg.op == OP_ALLOC)
        else $error("allocation count changed without an allocation");

endmodule

@@ dv/bitmap_page_allocator_tb.sv @@
// Self-checking testbench for the bitmap page allocator: directed and random page actions
// with random stalls on both stream sides, checked against an in-bench shadow allocator.
// Depends on bpa_pkg and bitmap_page_allocator from the RTL.
`timescale 1ns / 1ps

module bitmap_page_allocator_tb;
    import bpa_pkg::*;

    localparam time CLK_PERIOD = 20ns;
    // Slowest legal quiet stretch is a long receiver stall plus a full map scan.
    localparam int IDLE_LIMIT = 4000;
    localparam int SETTLE_CYCLES = 200;
    localparam logic [APB_ADDR_W-1:0] TOTAL_PAGES_ADDR = APB_ADDR_W'(4 * REG_TOTAL_PAGES);

    // One result transaction, first field in the lowest bits.
    typedef struct packed {
        logic [TOTAL_W-1:0] alloc_total;
        cnt_t               free_count;
        cnt_t               used_count;
        logic               page_used;
        logic [ADDR_W-1:0]  alloc_address;
        logic               ok;
    } page_result_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_W-1:0]       s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_W-1:0]      m_tdata;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // Shadow copy of the allocator state.
    logic [NUM_PAGES-1:0] shadow_map;
    cnt_t                 configured_pages;
    cnt_t                 used_pages;
    cnt_t                 free_pages;
    logic [TOTAL_W-1:0]   alloc_count;
    int unsigned          alloc_peak;

    page_result_t pending_page_results[$];
    int           error_count = 0;
    bit           tx_throttle = 1'b0;
    bit           rx_throttle = 1'b0;
    int           rx_hold = 0;
    int           quiet_cycles = 0;

    bitmap_page_allocator i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 15);
        if (roll < 12) begin
            return $urandom_range(1, 3);
        end else if (roll < 15) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(30, 150);
    endfunction

    function automatic int unsigned page_limit();
        return (configured_pages > NUM_PAGES) ? NUM_PAGES : configured_pages;
    endfunction

    // Reserved pages used, the rest free; the allocation count survives.
    function automatic void init_shadow_map();
        int unsigned lim;
        lim = page_limit();
        shadow_map = '0;
        for (int p = 0; p < RESERVED_PAGES; p++) begin
            shadow_map[p] = 1'b1;
        end
        used_pages = cnt_t'(RESERVED_PAGES);
        free_pages = (lim > RESERVED_PAGES) ? cnt_t'(lim - RESERVED_PAGES) : '0;
        alloc_peak = RESERVED_PAGES;
    endfunction

    // Applies one page action to the shadow state and returns the result it must give.
    function automatic page_result_t apply_page_action(input op_t act, input logic [31:0] addr);
        page_result_t res;
        int unsigned  page;
        int unsigned  lim;
        res = '0;
        page = addr >> PAGE_SHIFT;
        lim = page_limit();
        case (act)
            OP_ALLOC: begin
                // First fit above the reserved region.
                for (int unsigned p = RESERVED_PAGES; p < lim; p++) begin
                    if (!shadow_map[p]) begin
                        shadow_map[p] = 1'b1;
                        if (used_pages < CNT_MAX) used_pages++;
                        if (free_pages > 0) free_pages--;
                        alloc_count++;
                        res.alloc_address = ADDR_W'(p << PAGE_SHIFT);
                        res.ok = 1'b1;
                        if (p > alloc_peak) alloc_peak = p;
                        break;
                    end
                end
            end
            OP_FREE: begin
                if (page >= RESERVED_PAGES && page < lim && shadow_map[page]) begin
                    shadow_map[page] = 1'b0;
                    if (used_pages > 0) used_pages--;
                    if (free_pages < CNT_MAX) free_pages++;
                    res.ok = 1'b1;
                end
            end
            OP_QUERY: begin
                res.page_used = (page < NUM_PAGES) ? shadow_map[page] : 1'b0;
            end
            default: begin
            end
        endcase
        res.used_count = used_pages;
        res.free_count = free_pages;
        res.alloc_total = alloc_count;
        return res;
    endfunction

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", field, want, got);
            error_count++;
        end
    endtask

    // Sends one page action and waits for the transaction to be accepted.
    task automatic send_request(input op_t act, input logic [31:0] addr);
        int gap;
        s_tdata <= {{(IN_W - ADDR_W - ACT_W){1'b0}}, addr, act};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_page_results.push_back(apply_page_action(act, addr));
        if (tx_throttle && $urandom_range(0, 2) == 0) begin
            gap = pick_gap();
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Stops sending and waits until every expected result has arrived.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_page_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // One APB transfer: setup cycle, then access until pready.
    task automatic apb_transfer(input bit write, input logic [APB_DATA_W-1:0] wdata,
                                output logic [APB_DATA_W-1:0] rdata);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= write;
        paddr <= TOTAL_PAGES_ADDR;
        pwdata <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge aclk);
    endtask

    // Writes total_pages while idle, mirrors the re-initialization and reads it back.
    task automatic write_total_pages(input cnt_t pages);
        logic [APB_DATA_W-1:0] rdata;
        wait_drained();
        apb_transfer(1'b1, APB_DATA_W'(pages), rdata);
        configured_pages = pages;
        init_shadow_map();
        apb_transfer(1'b0, '0, rdata);
        check_field("total_pages", APB_DATA_W'(pages), rdata);
    endtask

    // Random action, with addresses mostly around the pages in use.
    task automatic send_random_request(input int alloc_pct);
        int          roll;
        int unsigned page;
        int unsigned lim;
        logic [31:0] addr;
        op_t         act;
        roll = $urandom_range(0, 99);
        if (roll < alloc_pct) begin
            act = OP_ALLOC;
        end else begin
            roll = $urandom_range(0, 9);
            if (roll < 5) begin
                act = OP_FREE;
            end else if (roll < 9) begin
                act = OP_QUERY;
            end else begin
                act = OP_NOP;
            end
        end
        lim = page_limit();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: page = $urandom_range(RESERVED_PAGES - 4, alloc_peak + 4);
            6: page = $urandom_range(lim - 2, lim + 1);
            7: page = $urandom_range(0, NUM_PAGES + 15);
            default: page = '1;
        endcase
        if (page == '1) begin
            addr = $urandom();
        end else begin
            addr = (page << PAGE_SHIFT) | $urandom_range(0, PAGE_BYTES - 1);
        end
        send_request(act, addr);
        // Now and then the sender holds off until the pipeline is empty.
        if ($urandom_range(0, 59) == 0) wait_drained();
    endtask

    task automatic run_random_phase(input cnt_t pages, input int items, input int alloc_pct,
                                    input bit tx_idle, input bit rx_idle);
        write_total_pages(pages);
        tx_throttle = tx_idle;
        rx_throttle = rx_idle;
        repeat (items) send_random_request(alloc_pct);
    endtask

    // Field extremes, every action and the documented corner cases.
    task automatic test_directed_cases();
        tx_throttle = 1'b1;
        rx_throttle = 1'b1;
        send_request(OP_QUERY, 32'h0000_0000);
        send_request(OP_QUERY, 32'h000F_FFFF);
        send_request(OP_QUERY, 32'h0010_0000);
        send_request(OP_ALLOC, 32'h0000_0000);
        send_request(OP_ALLOC, 32'h0000_0000);
        send_request(OP_QUERY, 32'h0010_0ABC);
        send_request(OP_FREE, 32'h0010_0FFF);
        // Freeing a page that is already free is ignored.
        send_request(OP_FREE, 32'h0010_0000);
        send_request(OP_ALLOC, 32'hFFFF_FFFF);
        send_request(OP_FREE, 32'h0000_0000);
        send_request(OP_FREE, 32'hFFFF_FFFF);
        send_request(OP_QUERY, 32'hFFFF_FFFF);
        send_request(OP_QUERY, 32'h00FF_F000);
        send_request(OP_FREE, 32'h00FF_FFFF);
        send_request(OP_QUERY, 32'h0100_0000);
        send_request(OP_NOP, 32'hFFFF_FFFF);
        send_request(OP_NOP, 32'h0000_0000);
        send_request(OP_FREE, 32'h0010_1000);
        // Smallest map: nothing above the reserved region to allocate.
        write_total_pages(cnt_t'(RESERVED_PAGES));
        send_request(OP_ALLOC, 32'h0000_0000);
        send_request(OP_FREE, 32'h0010_0000);
        send_request(OP_QUERY, 32'h0010_0000);
        send_request(OP_QUERY, 32'h0000_0000);
    endtask

    task automatic test_min_map_size();
        run_random_phase(cnt_t'(RESERVED_PAGES), 40, 40, 1'b1, 1'b1);
    endtask

    // Small maps fill up, so failed allocations and frees of used pages are common.
    task automatic test_small_map_exhaustion();
        run_random_phase(13'd288, 200, 55, 1'b1, 1'b1);
        run_random_phase(13'd257, 60, 50, 1'b1, 1'b0);
    endtask

    task automatic test_large_map_traffic();
        run_random_phase(cnt_t'(TOTAL_RESET), 300, 45, 1'b1, 1'b1);
        run_random_phase(13'd4095, 150, 40, 1'b0, 1'b0);
    endtask

    task automatic test_varied_map_sizes();
        repeat (4) begin
            run_random_phase(cnt_t'($urandom_range(258, 600)), 80, $urandom_range(30, 70),
                             1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
        run_random_phase(cnt_t'(TOTAL_RESET), 90, 80, 1'b1, 1'b1);
    endtask

    // Receiver side: random stalls while throttling, otherwise always ready.
    always @(posedge aclk) begin
        if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
            m_tready <= 1'b0;
        end else if (rx_throttle && $urandom_range(0, 3) == 0) begin
            rx_hold <= pick_gap() - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Compare each result transaction with the oldest expectation.
    always @(posedge aclk) begin : check_results
        page_result_t got;
        page_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = page_result_t'(m_tdata[OUT_FIELDS_W-1:0]);
            if (pending_page_results.size() == 0) begin
                $error("result transaction with no expected result");
                error_count++;
            end else begin
                want = pending_page_results.pop_front();
                check_field("ok", 32'(want.ok), 32'(got.ok));
                check_field("alloc_address", want.alloc_address, got.alloc_address);
                check_field("page_used", 32'(want.page_used), 32'(got.page_used));
                check_field("used_count", 32'(want.used_count), 32'(got.used_count));
                check_field("free_count", 32'(want.free_count), 32'(got.free_count));
                check_field("alloc_total", want.alloc_total, got.alloc_total);
                check_field("zero fill", '0, 32'(m_tdata[OUT_W-1:OUT_FIELDS_W]));
            end
        end
    end

    // Watchdog: ends the run when nothing moves for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        configured_pages = cnt_t'(TOTAL_RESET);
        alloc_count = '0;
        init_shadow_map();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_cases();
        test_min_map_size();
        test_small_map_exhaustion();
        test_large_map_traffic();
        test_varied_map_sizes();

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (pending_page_results.size() != 0) begin
            $error("%0d expected results never arrived", pending_page_results.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
